// File: rtl/nsc_pkg.sv
package nsc_pkg;

  // Register offsets that the channel decodes.
  localparam logic [4:0] OFF_VOLUME = 5'h0C;
  localparam logic [4:0] OFF_PERIOD = 5'h0E;
  localparam logic [4:0] OFF_LENGTH = 5'h0F;
  localparam logic [4:0] OFF_STATUS = 5'h15;
  localparam logic [4:0] OFF_FRAME  = 5'h17;

  // Fractional timer and frame sequencer increments per sample tick, and the frame period.
  localparam logic [19:0] TICK_STEP    = 20'd10384;
  localparam logic [16:0] FRAME_ADD    = 17'd649;
  localparam logic [16:0] FRAME_PERIOD = 17'd119318;

  typedef struct packed {
    logic write_en;
    logic tick_en;
    logic step_en;
    logic load_out;
  } nsc_cmd_t;

  typedef struct packed {
    logic tick_quiet;
    logic step_more;
    logic out_free;
  } nsc_sts_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   default: v = 8'd30;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] period_lookup(input logic [3:0] idx);
    logic [10:0] v;
    case (idx)
      4'd0:  v = 11'h002;  4'd1:  v = 11'h004;  4'd2:  v = 11'h008;  4'd3:  v = 11'h010;
      4'd4:  v = 11'h020;  4'd5:  v = 11'h030;  4'd6:  v = 11'h040;  4'd7:  v = 11'h050;
      4'd8:  v = 11'h065;  4'd9:  v = 11'h07F;  4'd10: v = 11'h0BE;  4'd11: v = 11'h0FE;
      4'd12: v = 11'h17D;  4'd13: v = 11'h1FC;  4'd14: v = 11'h3F9;  default: v = 11'h7F2;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] level_lookup(input logic [3:0] idx);
    logic [14:0] v;
    case (idx)
      4'd0:  v = 15'd0;      4'd1:  v = 15'd1092;   4'd2:  v = 15'd2184;
      4'd3:  v = 15'd3276;   4'd4:  v = 15'd4369;   4'd5:  v = 15'd5461;
      4'd6:  v = 15'd6553;   4'd7:  v = 15'd7645;   4'd8:  v = 15'd8738;
      4'd9:  v = 15'd9830;   4'd10: v = 15'd10922;  4'd11: v = 15'd12014;
      4'd12: v = 15'd13107;  4'd13: v = 15'd14199;  4'd14: v = 15'd15291;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/nsc_datapath.sv
module nsc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  nsc_pkg::nsc_cmd_t cmd,
  output nsc_pkg::nsc_sts_t sts,
  input  logic [4:0]       in_reg_offset,
  input  logic [7:0]       in_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [14:0]      out_level,
  output logic [3:0]       out_volume
);

  logic [14:0] noise_shift_r, noise_shift_nxt;
  logic [19:0] timer_accum_r, timer_accum_nxt;
  logic [10:0] period_r, period_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [3:0]  decay_r, decay_nxt;
  logic [3:0]  env_div_r, env_div_nxt;
  logic        env_restart_r, env_restart_nxt;
  logic [5:0]  vol_reg_r, vol_reg_nxt;
  logic        short_r, short_nxt;
  logic        enable_r, enable_nxt;
  logic        five_r, five_nxt;
  logic [16:0] frame_accum_r, frame_accum_nxt;
  logic [2:0]  frame_step_r, frame_step_nxt;
  logic [3:0]  held_vol_r, held_vol_nxt;
  logic [3:0]  vol_pre_r, vol_pre_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [14:0] out_level_r, out_level_nxt;
  logic [3:0]  out_volume_r, out_volume_nxt;

  logic [16:0] fa_sum;
  logic        fa_wrap;
  logic [2:0]  fstep_inc;
  logic        quarter;
  logic        full;
  logic [3:0]  env_div_t;
  logic [3:0]  decay_t;
  logic        restart_t;
  logic [3:0]  vol_t;
  logic [7:0]  length_t;
  logic [19:0] thr;
  logic        more;
  logic        fb;

  // The LFSR is clocked once per (period + 1) * 256 timer units.
  assign thr  = {12'(period_r) + 12'd1, 8'd0};
  assign more = timer_accum_r >= thr;
  assign fb   = short_r ? (noise_shift_r[6] ^ noise_shift_r[0])
                        : (noise_shift_r[1] ^ noise_shift_r[0]);

  always_comb begin
    fa_sum    = frame_accum_r + nsc_pkg::FRAME_ADD;
    fa_wrap   = fa_sum >= nsc_pkg::FRAME_PERIOD;
    fstep_inc = frame_step_r + 3'd1;
    quarter   = 1'b0;
    full      = 1'b0;
    if (fa_wrap) begin
      quarter = (fstep_inc != 3'd4) || !five_r;
      full    = fstep_inc == (five_r ? 3'd5 : 3'd4);
    end

    env_div_t = env_div_r;
    decay_t   = decay_r;
    restart_t = env_restart_r;
    if (quarter) begin
      if (env_restart_r) begin
        decay_t   = 4'd15;
        env_div_t = vol_reg_r[3:0];
        restart_t = 1'b0;
      end else if (env_div_r != 4'd0) begin
        env_div_t = env_div_r - 4'd1;
      end else begin
        env_div_t = vol_reg_r[3:0];
        if (decay_r != 4'd0) begin
          decay_t = decay_r - 4'd1;
        end else if (vol_reg_r[5]) begin
          decay_t = 4'd15;
        end
      end
    end
    vol_t = vol_reg_r[4] ? vol_reg_r[3:0] : decay_t;

    length_t = length_r;
    if (!vol_reg_r[5] && (length_r != 8'd0) && full) begin
      length_t = length_r - 8'd1;
    end
  end

  assign sts.tick_quiet = !enable_r || (length_t == 8'd0);
  assign sts.step_more  = more;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    noise_shift_nxt = noise_shift_r;
    timer_accum_nxt = timer_accum_r;
    period_nxt      = period_r;
    length_nxt      = length_r;
    decay_nxt       = decay_r;
    env_div_nxt     = env_div_r;
    env_restart_nxt = env_restart_r;
    vol_reg_nxt     = vol_reg_r;
    short_nxt       = short_r;
    enable_nxt      = enable_r;
    five_nxt        = five_r;
    frame_accum_nxt = frame_accum_r;
    frame_step_nxt  = frame_step_r;
    held_vol_nxt    = held_vol_r;
    vol_pre_nxt     = vol_pre_r;
    out_valid_nxt   = out_valid_r;
    out_level_nxt   = out_level_r;
    out_volume_nxt  = out_volume_r;

    if (cmd.tick_en) begin
      frame_accum_nxt = fa_wrap ? (fa_sum - nsc_pkg::FRAME_PERIOD) : fa_sum;
      if (full) begin
        frame_step_nxt = 3'd0;
      end else if (fa_wrap) begin
        frame_step_nxt = fstep_inc;
      end
      if (!enable_r) begin
        held_vol_nxt = 4'd0;
      end else begin
        env_div_nxt     = env_div_t;
        decay_nxt       = decay_t;
        env_restart_nxt = restart_t;
        length_nxt      = length_t;
        if (length_t == 8'd0) begin
          held_vol_nxt = 4'd0;
        end else begin
          timer_accum_nxt = timer_accum_r + nsc_pkg::TICK_STEP;
          vol_pre_nxt     = vol_t;
        end
      end
    end

    if (cmd.write_en) begin
      unique case (in_reg_offset)
        nsc_pkg::OFF_VOLUME: begin
          vol_reg_nxt = in_data[5:0];
          env_div_nxt = in_data[3:0];
        end
        nsc_pkg::OFF_PERIOD: begin
          period_nxt = nsc_pkg::period_lookup(in_data[3:0]);
          short_nxt  = in_data[7];
        end
        nsc_pkg::OFF_LENGTH: begin
          if (!vol_reg_r[5]) begin
            length_nxt = nsc_pkg::len_lookup(in_data[7:3]);
          end
          timer_accum_nxt = 20'd0;
          env_restart_nxt = 1'b1;
        end
        nsc_pkg::OFF_STATUS: begin
          enable_nxt = in_data[3];
          if (!in_data[3]) begin
            timer_accum_nxt = 20'd0;
          end
        end
        nsc_pkg::OFF_FRAME: begin
          five_nxt        = in_data[7];
          frame_accum_nxt = 17'd0;
          frame_step_nxt  = 3'd0;
        end
        default: begin
        end
      endcase
    end

    // One LFSR clock per cycle until the timer drops below the threshold.
    if (cmd.step_en) begin
      if (more) begin
        noise_shift_nxt = {fb, noise_shift_r[14:1]};
        timer_accum_nxt = timer_accum_r - thr;
      end else begin
        held_vol_nxt = noise_shift_r[0] ? 4'd0 : vol_pre_r;
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_level_nxt  = nsc_pkg::level_lookup(held_vol_r);
      out_volume_nxt = held_vol_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_shift_r <= 15'd1;
      timer_accum_r <= 20'd0;
      period_r      <= 11'd0;
      length_r      <= 8'd0;
      decay_r       <= 4'd0;
      env_div_r     <= 4'd0;
      env_restart_r <= 1'b0;
      vol_reg_r     <= 6'd0;
      short_r       <= 1'b0;
      enable_r      <= 1'b0;
      five_r        <= 1'b0;
      frame_accum_r <= 17'd0;
      frame_step_r  <= 3'd0;
      held_vol_r    <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      noise_shift_r <= noise_shift_nxt;
      timer_accum_r <= timer_accum_nxt;
      period_r      <= period_nxt;
      length_r      <= length_nxt;
      decay_r       <= decay_nxt;
      env_div_r     <= env_div_nxt;
      env_restart_r <= env_restart_nxt;
      vol_reg_r     <= vol_reg_nxt;
      short_r       <= short_nxt;
      enable_r      <= enable_nxt;
      five_r        <= five_nxt;
      frame_accum_r <= frame_accum_nxt;
      frame_step_r  <= frame_step_nxt;
      held_vol_r    <= held_vol_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vol_pre_r    <= vol_pre_nxt;
    out_level_r  <= out_level_nxt;
    out_volume_r <= out_volume_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_volume = out_volume_r;

  // An XOR shift register started from a nonzero value never reaches zero.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    noise_shift_r != 15'd0)
    else $error("noise shift register reached zero");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_step_r <= 3'd4) && (five_r || (frame_step_r <= 3'd3)))
    else $error("frame step out of range for the sequencer mode");

endmodule

// File: rtl/nsc_ctrl.sv
module nsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  nsc_pkg::nsc_sts_t sts,
  output nsc_pkg::nsc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOP = 3'b010,
    ST_FIN  = 3'b100
  } nsc_state_t;

  nsc_state_t state_r, state_nxt;
  logic       accept;

  assign in_ready = state_r == ST_IDLE;
  assign accept   = in_valid && in_ready;

  assign cmd.write_en = accept && !in_action;
  assign cmd.tick_en  = accept && in_action;
  assign cmd.step_en  = state_r == ST_LOOP;
  assign cmd.load_out = (state_r == ST_FIN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_action && !sts.tick_quiet) ? ST_LOOP : ST_FIN;
        end
      end
      ST_LOOP: begin
        if (!sts.step_more) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_write_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_action) |=> (state_r == ST_FIN))
    else $error("register write did not go straight to the result state");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while the output register is occupied");

  a_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick_en && sts.tick_quiet) |=> (state_r == ST_FIN))
    else $error("silent tick entered the timer loop");

endmodule

// File: rtl/noise_sound_channel.sv
// Channel  Ports                                     Direction
// input    in_valid/in_ready, in_action,             in
//          in_reg_offset, in_data
// result   out_valid/out_ready, out_level,           out
//          out_volume
// A register write, or a tick while disabled or at zero length, goes from acceptance
// straight to the result state; any other tick first runs the timer loop, clocking the
// noise shift register once per cycle until the timer drops below the threshold. Reset is
// synchronous and active low; the shift register starts at 1, vol_pre and the output data
// are not reset, and all else is 0. A result waits in the output register; no new item
// is taken until it is loaded.
module noise_sound_channel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [4:0]  in_reg_offset,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_level,
  output logic [3:0]  out_volume
);

  nsc_pkg::nsc_cmd_t cmd;
  nsc_pkg::nsc_sts_t sts;

  nsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsc_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_reg_offset (in_reg_offset),
    .in_data       (in_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_level     (out_level),
    .out_volume    (out_volume)
  );

endmodule
